FILE: rtl/conformal_map_triangle_coefficients_assert.svh
// Assertion macros shared by the block's modules.
`ifndef CONFORMAL_MAP_TRIANGLE_COEFFICIENTS_ASSERT_SVH
`define CONFORMAL_MAP_TRIANGLE_COEFFICIENTS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CMTC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define CMTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/cmtc_pkg.sv
package cmtc_pkg;

   localparam int VERTEX_ID_BITS = 20;
   localparam int TRIANGLE_BITS  = 20;
   localparam int COORD_BITS     = 32;
   localparam int COEF_BITS      = 36;
   localparam int DIFF_BITS      = COORD_BITS + 1;
   localparam int MUL_BITS       = 35;
   localparam int PROD_BITS      = 2 * MUL_BITS;
   localparam int ACC_BITS       = 68;
   localparam int ROOT_BITS      = ACC_BITS / 2;
   localparam int VAL_BITS       = 38;
   localparam int STEP_BITS      = 7;
   localparam int EMIT_BITS      = 4;

   localparam int MUL_LAST_STEP  = 15;
   localparam int ROOT_STEPS     = ROOT_BITS;
   localparam int DIV_STEPS      = ACC_BITS;
   localparam int EMIT_LAST      = 9;

   typedef struct packed {
      logic [VERTEX_ID_BITS-1:0]    first_id;
      logic [VERTEX_ID_BITS-1:0]    second_id;
      logic [VERTEX_ID_BITS-1:0]    third_id;
      logic signed [COORD_BITS-1:0] first_px;
      logic signed [COORD_BITS-1:0] first_py;
      logic signed [COORD_BITS-1:0] first_pz;
      logic signed [COORD_BITS-1:0] second_px;
      logic signed [COORD_BITS-1:0] second_py;
      logic signed [COORD_BITS-1:0] second_pz;
      logic signed [COORD_BITS-1:0] third_px;
      logic signed [COORD_BITS-1:0] third_py;
      logic signed [COORD_BITS-1:0] third_pz;
   } req_type;

   typedef struct packed {
      logic [VERTEX_ID_BITS:0]     var_index;
      logic [TRIANGLE_BITS:0]      eq_row;
      logic signed [COEF_BITS-1:0] coefficient;
      logic                        degenerate;
      logic                        last;
   } rsp_type;

   typedef enum logic [3:0] {
      DP_IDLE,
      DP_LOAD,
      DP_MUL,
      DP_ROOT_A_INIT,
      DP_ROOT,
      DP_DIV_INIT,
      DP_DIV,
      DP_CSQ,
      DP_ROOT_D_INIT,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type            op;
      logic [STEP_BITS-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic degen;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/cmtc_ctrl.sv
`include "conformal_map_triangle_coefficients_assert.svh"

module cmtc_ctrl
   import cmtc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output cmd_type    cmd,
   output logic       idle
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MUL    = 7'b0000010,
      ST_ROOT_A = 7'b0000100,
      ST_DIV    = 7'b0001000,
      ST_CSQ    = 7'b0010000,
      ST_ROOT_D = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd.op   = DP_IDLE;
      cmd.step = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = ST_MUL;
               step_in  = '0;
            end
         end
         ST_MUL: begin
            cmd.op = DP_MUL;
            if (step_ff == STEP_BITS'(MUL_LAST_STEP)) begin
               state_in = ST_ROOT_A;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_ROOT_A: begin
            if (step_ff == '0) begin
               cmd.op = DP_ROOT_A_INIT;
               if (status.degen) begin
                  state_in = ST_EMIT;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end else begin
               cmd.op = DP_ROOT;
               if (step_ff == STEP_BITS'(ROOT_STEPS)) begin
                  state_in = ST_DIV;
                  step_in  = '0;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         ST_DIV: begin
            cmd.op = (step_ff == '0) ? DP_DIV_INIT : DP_DIV;
            if (step_ff == STEP_BITS'(DIV_STEPS)) begin
               state_in = ST_CSQ;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_CSQ: begin
            cmd.op   = DP_CSQ;
            state_in = ST_ROOT_D;
            step_in  = '0;
         end
         ST_ROOT_D: begin
            cmd.op = (step_ff == '0) ? DP_ROOT_D_INIT : DP_ROOT;
            if (step_ff == STEP_BITS'(ROOT_STEPS)) begin
               state_in = ST_EMIT;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.op = DP_EMIT;
               if (step_ff == STEP_BITS'(EMIT_LAST)) begin
                  state_in = ST_IDLE;
                  step_in  = '0;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign idle = (state_ff == ST_IDLE);

   `CMTC_ASSERT_NEXT(a_accept_starts, clock, reset, idle && req_valid, state_ff == ST_MUL)
   `CMTC_ASSERT_NEXT(a_last_returns_idle, clock, reset,
      cmd.op == DP_EMIT && cmd.step == STEP_BITS'(EMIT_LAST), idle)

endmodule

FILE: rtl/cmtc_datapath.sv
`include "conformal_map_triangle_coefficients_assert.svh"

module cmtc_datapath
   import cmtc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   input  logic       rsp_stall,
   output status_type status,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   function automatic logic signed [COEF_BITS-1:0] sat_coef(input logic signed [VAL_BITS-1:0] v);
      logic signed [VAL_BITS-1:0] hi;
      logic signed [VAL_BITS-1:0] lo;
      hi = VAL_BITS'((64'sd1 <<< (COEF_BITS - 1)) - 64'sd1);
      lo = -VAL_BITS'(64'sd1 <<< (COEF_BITS - 1));
      if (v > hi) begin
         return hi[COEF_BITS-1:0];
      end else if (v < lo) begin
         return lo[COEF_BITS-1:0];
      end
      return v[COEF_BITS-1:0];
   endfunction

   logic [VERTEX_ID_BITS-1:0]   id_ff [3];
   logic signed [DIFF_BITS-1:0] e1_ff [3];
   logic signed [DIFF_BITS-1:0] e2_ff [3];

   logic signed [PROD_BITS-1:0] prod_ff;
   logic [3:0]                  prod_tag_ff;
   logic                        prod_vld_ff;
   logic signed [ACC_BITS-1:0]  s1_ff, s2_ff, dot_ff, xacc_ff;
   logic                        cross_nz_ff;
   logic                        degen_ff, cneg_ff;

   logic [ACC_BITS-1:0]         rad_ff;
   logic [ROOT_BITS+2:0]        rrem_ff;
   logic [ROOT_BITS-1:0]        root_ff;
   logic [ROOT_BITS-1:0]        a_ff;
   logic [ACC_BITS-1:0]         num_ff;
   logic [ROOT_BITS-1:0]        drem_ff;
   logic signed [ROOT_BITS+1:0] c_ff;

   logic [TRIANGLE_BITS-1:0]    count_ff;
   logic                        rsp_valid_ff;
   rsp_type                     rsp_data_ff;

   logic signed [MUL_BITS-1:0]  op_a, op_b;
   logic signed [ACC_BITS-1:0]  p;
   logic [ROOT_BITS+4:0]        rem_sh, trial;
   logic [ROOT_BITS:0]          drem_sh;
   logic signed [PROD_BITS-1:0] dsq;
   logic [EMIT_BITS-1:0]        k;
   logic signed [VAL_BITS-1:0]  va, vc, vd, val;
   logic [VERTEX_ID_BITS-1:0]   id_sel;
   logic                        vbit;
   logic signed [MUL_BITS-1:0]  cu_op;

   assign p     = prod_ff[ACC_BITS-1:0];
   assign cu_op = MUL_BITS'({1'b0, num_ff[ROOT_BITS-1:0]});

   // Operand selection for the shared multiplier.
   always_comb begin
      op_a = cu_op;
      op_b = cu_op;
      if (cmd.op == DP_MUL) begin
         case (cmd.step[3:0])
            4'd0:    begin op_a = MUL_BITS'(e1_ff[0]); op_b = MUL_BITS'(e1_ff[0]); end
            4'd1:    begin op_a = MUL_BITS'(e1_ff[1]); op_b = MUL_BITS'(e1_ff[1]); end
            4'd2:    begin op_a = MUL_BITS'(e1_ff[2]); op_b = MUL_BITS'(e1_ff[2]); end
            4'd3:    begin op_a = MUL_BITS'(e2_ff[0]); op_b = MUL_BITS'(e2_ff[0]); end
            4'd4:    begin op_a = MUL_BITS'(e2_ff[1]); op_b = MUL_BITS'(e2_ff[1]); end
            4'd5:    begin op_a = MUL_BITS'(e2_ff[2]); op_b = MUL_BITS'(e2_ff[2]); end
            4'd6:    begin op_a = MUL_BITS'(e1_ff[0]); op_b = MUL_BITS'(e2_ff[0]); end
            4'd7:    begin op_a = MUL_BITS'(e1_ff[1]); op_b = MUL_BITS'(e2_ff[1]); end
            4'd8:    begin op_a = MUL_BITS'(e1_ff[2]); op_b = MUL_BITS'(e2_ff[2]); end
            4'd9:    begin op_a = MUL_BITS'(e1_ff[1]); op_b = MUL_BITS'(e2_ff[2]); end
            4'd10:   begin op_a = MUL_BITS'(e1_ff[2]); op_b = MUL_BITS'(e2_ff[1]); end
            4'd11:   begin op_a = MUL_BITS'(e1_ff[2]); op_b = MUL_BITS'(e2_ff[0]); end
            4'd12:   begin op_a = MUL_BITS'(e1_ff[0]); op_b = MUL_BITS'(e2_ff[2]); end
            4'd13:   begin op_a = MUL_BITS'(e1_ff[0]); op_b = MUL_BITS'(e2_ff[1]); end
            4'd14:   begin op_a = MUL_BITS'(e1_ff[1]); op_b = MUL_BITS'(e2_ff[0]); end
            default: begin op_a = '0; op_b = '0; end
         endcase
      end
   end

   assign rem_sh  = {rrem_ff, rad_ff[ACC_BITS-1 -: 2]};
   assign trial   = {3'b000, root_ff, 2'b01};
   assign drem_sh = {drem_ff, num_ff[ACC_BITS-1]};
   assign dsq     = PROD_BITS'(s2_ff) - prod_ff;

   // Coefficient selection for the current result slot.
   assign k  = cmd.step[EMIT_BITS-1:0];
   assign va = VAL_BITS'({1'b0, a_ff});
   assign vd = VAL_BITS'({1'b0, root_ff});
   assign vc = VAL_BITS'(c_ff);

   always_comb begin
      val    = va;
      id_sel = id_ff[0];
      vbit   = 1'b0;
      case (k) inside
         4'd0, 4'd6: val = vc - va;
         4'd1, 4'd7: val = -vd;
         4'd2, 4'd8: val = -vc;
         4'd3, 4'd5: val = vd;
         default:    val = va;
      endcase
      case (k) inside
         4'd0, 4'd5: begin id_sel = id_ff[0]; vbit = 1'b0; end
         4'd1, 4'd6: begin id_sel = id_ff[0]; vbit = 1'b1; end
         4'd2, 4'd7: begin id_sel = id_ff[1]; vbit = 1'b0; end
         4'd3, 4'd8: begin id_sel = id_ff[1]; vbit = 1'b1; end
         4'd4:       begin id_sel = id_ff[2]; vbit = 1'b0; end
         default:    begin id_sel = id_ff[2]; vbit = 1'b1; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff     <= op_a * op_b;
      prod_tag_ff <= cmd.step[3:0];

      if (prod_vld_ff) begin
         case (prod_tag_ff) inside
            4'd0, 4'd1, 4'd2:    s1_ff   <= s1_ff + p;
            4'd3, 4'd4, 4'd5:    s2_ff   <= s2_ff + p;
            4'd6, 4'd7, 4'd8:    dot_ff  <= dot_ff + p;
            4'd9, 4'd11, 4'd13:  xacc_ff <= p;
            default: begin
               if (xacc_ff != p) begin
                  cross_nz_ff <= 1'b1;
               end
            end
         endcase
      end

      case (cmd.op)
         DP_LOAD: begin
            id_ff[0]    <= req_data.first_id;
            id_ff[1]    <= req_data.second_id;
            id_ff[2]    <= req_data.third_id;
            e1_ff[0]    <= DIFF_BITS'(req_data.second_px) - DIFF_BITS'(req_data.first_px);
            e1_ff[1]    <= DIFF_BITS'(req_data.second_py) - DIFF_BITS'(req_data.first_py);
            e1_ff[2]    <= DIFF_BITS'(req_data.second_pz) - DIFF_BITS'(req_data.first_pz);
            e2_ff[0]    <= DIFF_BITS'(req_data.third_px) - DIFF_BITS'(req_data.first_px);
            e2_ff[1]    <= DIFF_BITS'(req_data.third_py) - DIFF_BITS'(req_data.first_py);
            e2_ff[2]    <= DIFF_BITS'(req_data.third_pz) - DIFF_BITS'(req_data.first_pz);
            s1_ff       <= '0;
            s2_ff       <= '0;
            dot_ff      <= '0;
            cross_nz_ff <= 1'b0;
         end
         DP_ROOT_A_INIT: begin
            rad_ff   <= s1_ff;
            rrem_ff  <= '0;
            root_ff  <= '0;
            degen_ff <= (s1_ff == '0) || !cross_nz_ff;
            cneg_ff  <= dot_ff < 0;
         end
         DP_ROOT: begin
            rad_ff <= {rad_ff[ACC_BITS-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rrem_ff <= (ROOT_BITS+3)'(rem_sh - trial);
               root_ff <= {root_ff[ROOT_BITS-2:0], 1'b1};
            end else begin
               rrem_ff <= (ROOT_BITS+3)'(rem_sh);
               root_ff <= {root_ff[ROOT_BITS-2:0], 1'b0};
            end
         end
         DP_DIV_INIT: begin
            a_ff    <= root_ff;
            num_ff  <= cneg_ff ? ACC_BITS'(-dot_ff) : ACC_BITS'(dot_ff);
            drem_ff <= '0;
         end
         DP_DIV: begin
            if (drem_sh >= {1'b0, a_ff}) begin
               drem_ff <= ROOT_BITS'(drem_sh - {1'b0, a_ff});
               num_ff  <= {num_ff[ACC_BITS-2:0], 1'b1};
            end else begin
               drem_ff <= drem_sh[ROOT_BITS-1:0];
               num_ff  <= {num_ff[ACC_BITS-2:0], 1'b0};
            end
         end
         DP_CSQ: begin
            c_ff <= cneg_ff ? -(ROOT_BITS+2)'({1'b0, num_ff[ROOT_BITS-1:0]})
                            :  (ROOT_BITS+2)'({1'b0, num_ff[ROOT_BITS-1:0]});
         end
         DP_ROOT_D_INIT: begin
            rad_ff  <= (dsq > 0) ? dsq[ACC_BITS-1:0] : '0;
            rrem_ff <= '0;
            root_ff <= '0;
         end
         DP_EMIT: begin
            rsp_data_ff.var_index   <= {id_sel, vbit};
            rsp_data_ff.eq_row      <= {count_ff, (k > 4'd4)};
            rsp_data_ff.coefficient <= degen_ff ? '0 : sat_coef(val);
            rsp_data_ff.degenerate  <= degen_ff;
            rsp_data_ff.last        <= (k == EMIT_BITS'(EMIT_LAST));
         end
         default: begin
         end
      endcase

      if (reset) begin
         prod_vld_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prod_vld_ff <= (cmd.op == DP_MUL) && (cmd.step != STEP_BITS'(MUL_LAST_STEP));
         if (cmd.op == DP_EMIT) begin
            rsp_valid_ff <= 1'b1;
            if (k == EMIT_BITS'(EMIT_LAST)) begin
               count_ff <= count_ff + 1'b1;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.degen    = (s1_ff == '0) || !cross_nz_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   `CMTC_ASSERT_IMPLY(a_emit_into_free_slot, clock, reset, cmd.op == DP_EMIT,
      !rsp_valid_ff || !rsp_stall)
   `CMTC_ASSERT_NEXT(a_count_steps_on_last, clock, reset,
      cmd.op == DP_EMIT && k == EMIT_BITS'(EMIT_LAST),
      count_ff == $past(count_ff) + 1'b1)
   `CMTC_ASSERT_IMPLY(a_degenerate_zero, clock, reset,
      rsp_valid_ff && rsp_data_ff.degenerate, rsp_data_ff.coefficient == '0)

endmodule

FILE: rtl/conformal_map_triangle_coefficients.sv
// Conformal map coefficient setup for one triangle per request.
// The request channel (req_valid, req_stall, req_data) carries three vertex
// ids and three corner positions in signed Q15.16. A request is taken when
// req_valid is high and req_stall is low; req_stall is low only while the
// block is idle, so one triangle is worked on at a time.
// Each triangle yields ten results on the response channel (rsp_valid,
// rsp_stall, rsp_data), each a variable index, an equation row and a
// saturated Q19.16 coefficient, with last set on the tenth.
// From request to the first result the block loads the request, runs the
// products on the shared multiplier, takes the square root for a (one bit
// of root per cycle), runs a restoring division for c (one quotient bit
// per cycle), squares c and takes the square root for d. Degenerate
// triangles skip the roots and the division. The ten results then leave
// at one per cycle while the receiver does not stall.
// The output register lets a new request be taken while the final result
// still waits. When the receiver stalls, the result register holds and the
// sequencer waits. Reset clears the sequencer, the triangle counter that
// sets the equation rows, and the response valid.
module conformal_map_triangle_coefficients
   import cmtc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;
   logic       idle;

   // The sequencer steps the datapath through load, products, roots,
   // division and the ten result slots.
   cmtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .idle      (idle)
   );

   // The datapath holds the edge vectors, the shared multiplier, the
   // bit-serial root and divide registers and the response register.
   cmtc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // New requests are refused while a triangle is in flight.
   assign req_stall = !idle;

endmodule

FILE: test/conformal_map_triangle_coefficients_tb.sv
module conformal_map_triangle_coefficients_tb;
   import cmtc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Each random triangle is followed by ten results. Rows come from a
   // counter of triangles accepted since reset, which the model below keeps.
   localparam int RANDOM_TRIANGLES = 200;
   localparam int DRAIN_PAUSE_AT   = 30;
   localparam int TAIL_CYCLES      = 400;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   conformal_map_triangle_coefficients u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   req_type                  triangles_pending[$];
   rsp_type                  coeffs_due[$];
   logic [TRIANGLE_BITS-1:0] triangle_count;
   int                       triangles_issued;
   int                       triangles_taken;
   int                       total_triangles;
   bit                       failed;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Idle percentages per phase, by requests issued (sender) or taken (receiver):
   // sender light and receiver heavy, then the reverse, then none.
   function automatic int phase_of(input int n);
      if (n < total_triangles / 3) return 0;
      if (n < (2 * total_triangles) / 3) return 1;
      return 2;
   endfunction

   function automatic int sender_idle_pct(input int n);
      case (phase_of(n))
         0: return 29;
         1: return 68;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct(input int n);
      case (phase_of(n))
         0: return 68;
         1: return 29;
         default: return 0;
      endcase
   endfunction

   // Floor of the square root of a 128-bit value, one root bit per pass.
   function automatic logic [63:0] floor_root(input logic [127:0] n);
      logic [63:0]  r;
      logic [63:0]  t;
      logic [127:0] sq;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         t  = r | (64'd1 << b);
         sq = {64'd0, t} * {64'd0, t};
         if (sq <= n) r = t;
      end
      return r;
   endfunction

   function automatic logic signed [COEF_BITS-1:0] clamp_coef(input longint v);
      if (v > 64'sd34359738367) return 36'sh7_FFFF_FFFF;
      if (v < -64'sd34359738368) return 36'sh8_0000_0000;
      return v[COEF_BITS-1:0];
   endfunction

   // Places the triangle in its own plane and queues its ten coefficients.
   function automatic void predict_coefficients(input req_type t);
      logic signed [127:0] e1[3];
      logic signed [127:0] e2[3];
      logic signed [127:0] p0[3];
      logic signed [127:0] p1[3];
      logic signed [127:0] p2[3];
      logic signed [127:0] len1_sq;
      logic signed [127:0] len2_sq;
      logic signed [127:0] dot;
      logic signed [127:0] c_sq;
      logic [127:0]        dot_mag;
      logic [63:0]         a_mag;
      logic [63:0]         c_mag;
      longint              a;
      longint              c;
      longint              d;
      longint              vals[10];
      logic [VERTEX_ID_BITS:0] vars[10];
      logic [TRIANGLE_BITS:0]  row0;
      logic [TRIANGLE_BITS:0]  row1;
      bit                  flat;
      rsp_type             r;
      p0[0] = t.first_px;  p0[1] = t.first_py;  p0[2] = t.first_pz;
      p1[0] = t.second_px; p1[1] = t.second_py; p1[2] = t.second_pz;
      p2[0] = t.third_px;  p2[1] = t.third_py;  p2[2] = t.third_pz;
      len1_sq = 0;
      len2_sq = 0;
      dot     = 0;
      for (int i = 0; i < 3; i++) begin
         e1[i]   = p1[i] - p0[i];
         e2[i]   = p2[i] - p0[i];
         len1_sq = len1_sq + e1[i] * e1[i];
         len2_sq = len2_sq + e2[i] * e2[i];
         dot     = dot + e1[i] * e2[i];
      end
      // A zero first edge or a zero cross product flattens the triangle.
      flat = (len1_sq == 0) ||
             ((e1[1] * e2[2] == e1[2] * e2[1]) &&
              (e1[2] * e2[0] == e1[0] * e2[2]) &&
              (e1[0] * e2[1] == e1[1] * e2[0]));
      a = 0;
      c = 0;
      d = 0;
      if (!flat) begin
         a_mag   = floor_root(len1_sq);
         dot_mag = (dot < 0) ? -dot : dot;
         c_mag   = 64'(dot_mag / {64'd0, a_mag});
         a       = longint'(a_mag);
         c       = (dot < 0) ? -longint'(c_mag) : longint'(c_mag);
         c_sq    = $signed({64'd0, c_mag}) * $signed({64'd0, c_mag});
         d       = (len2_sq > c_sq) ? longint'(floor_root(len2_sq - c_sq)) : 0;
      end
      vars[0] = {t.first_id, 1'b0};  vars[1] = {t.first_id, 1'b1};
      vars[2] = {t.second_id, 1'b0}; vars[3] = {t.second_id, 1'b1};
      vars[4] = {t.third_id, 1'b0};
      vars[5] = {t.first_id, 1'b0};  vars[6] = {t.first_id, 1'b1};
      vars[7] = {t.second_id, 1'b0}; vars[8] = {t.second_id, 1'b1};
      vars[9] = {t.third_id, 1'b1};
      vals[0] = c - a; vals[1] = -d; vals[2] = -c; vals[3] = d;  vals[4] = a;
      vals[5] = d; vals[6] = c - a; vals[7] = -d; vals[8] = -c; vals[9] = a;
      row0 = {triangle_count, 1'b0};
      row1 = {triangle_count, 1'b1};
      for (int k = 0; k < 10; k++) begin
         r.var_index   = vars[k];
         r.eq_row      = (k < 5) ? row0 : row1;
         r.coefficient = flat ? '0 : clamp_coef(vals[k]);
         r.degenerate  = flat;
         r.last        = (k == 9);
         coeffs_due.push_back(r);
      end
      triangle_count = triangle_count + 1'b1;
   endfunction

   function automatic req_type make_triangle(
      input logic [VERTEX_ID_BITS-1:0] i0, i1, i2,
      input logic [31:0] x0, y0, z0, x1, y1, z1, x2, y2, z2);
      req_type t;
      t.first_id  = i0; t.second_id = i1; t.third_id = i2;
      t.first_px  = x0; t.first_py  = y0; t.first_pz = z0;
      t.second_px = x1; t.second_py = y1; t.second_pz = z1;
      t.third_px  = x2; t.third_py  = y2; t.third_pz  = z2;
      return t;
   endfunction

   function automatic logic [VERTEX_ID_BITS-1:0] random_id();
      return VERTEX_ID_BITS'($urandom);
   endfunction

   // Coordinates near each other in Q15.16, so that most triangles have a
   // sane shape; a share of the coordinates use the whole 32-bit range.
   function automatic logic [31:0] random_coord(input bit full_range);
      if (full_range) return $urandom;
      return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
   endfunction

   // The driver holds a request steady while it is stalled and only then
   // draws the next one, with a random idle gap between requests. Once,
   // it holds off until the block has handed back every result.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_coefficients(req_data);
            triangles_taken++;
         end
         if (req_valid && req_stall) begin
            // The stalled request stays on the bus unchanged.
         end else if (triangles_pending.size() != 0 &&
                      !(triangles_issued == DRAIN_PAUSE_AT && coeffs_due.size() != 0) &&
                      $urandom_range(0, 99) >= sender_idle_pct(triangles_issued)) begin
            req_valid <= 1'b1;
            req_data  <= triangles_pending.pop_front();
            triangles_issued++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The monitor compares every result taken with the oldest one due and
   // draws the stall for the next cycle.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (coeffs_due.size() == 0) begin
               $error("result with none due: var_index %0d eq_row %0d",
                      rsp_data.var_index, rsp_data.eq_row);
               failed = 1'b1;
            end else begin
               want = coeffs_due.pop_front();
               if (rsp_data.var_index !== want.var_index) begin
                  $error("var_index expected %0d actual %0d",
                         want.var_index, rsp_data.var_index);
                  failed = 1'b1;
               end
               if (rsp_data.eq_row !== want.eq_row) begin
                  $error("eq_row expected %0d actual %0d", want.eq_row, rsp_data.eq_row);
                  failed = 1'b1;
               end
               if (rsp_data.coefficient !== want.coefficient) begin
                  $error("coefficient expected %0d actual %0d",
                         want.coefficient, rsp_data.coefficient);
                  failed = 1'b1;
               end
               if (rsp_data.degenerate !== want.degenerate) begin
                  $error("degenerate expected %0d actual %0d",
                         want.degenerate, rsp_data.degenerate);
                  failed = 1'b1;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last expected %0d actual %0d", want.last, rsp_data.last);
                  failed = 1'b1;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct(triangles_taken));
      end
   end

   initial begin
      bit wide;
      failed           = 1'b0;
      triangle_count   = '0;
      triangles_issued = 0;
      triangles_taken  = 0;
      req_valid        = 1'b0;
      req_data         = '0;
      rsp_stall        = 1'b0;
      reset            = 1'b1;

      // Directed triangles: a plain right triangle, all three corners on
      // one point, a zero first edge, collinear corners, a triangle with c
      // negative, extreme ids and the coordinate extremes, where the
      // coefficients reach their largest magnitudes.
      triangles_pending.push_back(make_triangle(0, 1, 2,
         0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0));
      triangles_pending.push_back(make_triangle(20'hFFFFF, 20'h00000, 20'h80000,
         32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 32'h0003_0000, 32'h0004_0000,
         32'h0005_0000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000));
      triangles_pending.push_back(make_triangle(7, 8, 9,
         32'h0001_0000, 32'h0002_0000, 0, 32'h0001_0000, 32'h0002_0000, 0,
         32'h0009_0000, 0, 32'h0001_0000));
      triangles_pending.push_back(make_triangle(3, 4, 5,
         0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
         32'hFFFE_0000, 32'hFFFC_0000, 32'hFFFA_0000));
      triangles_pending.push_back(make_triangle(10, 11, 12,
         0, 0, 0, 32'h0002_0000, 0, 0, 32'hFFFD_0000, 32'h0001_8000, 32'h0000_4000));
      triangles_pending.push_back(make_triangle(20'hFFFFF, 20'hFFFFE, 20'hFFFFF,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
      triangles_pending.push_back(make_triangle(1, 2, 3,
         32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
      triangles_pending.push_back(make_triangle(4, 5, 6,
         0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h8000_0000));
      triangles_pending.push_back(make_triangle(20'h55555, 20'hAAAAA, 20'h12345,
         32'h0000_0001, 0, 0, 32'h0000_0002, 0, 0, 32'h0000_0001, 32'h0000_0001, 0));
      triangles_pending.push_back(make_triangle(0, 0, 0,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));

      for (int n = 0; n < RANDOM_TRIANGLES; n++) begin
         wide = ($urandom_range(0, 99) < 25);
         if ($urandom_range(0, 99) < 5) begin
            // A flattened triangle: corners one and three on the same point.
            triangles_pending.push_back(make_triangle(random_id(), random_id(), random_id(),
               0, 0, 0, random_coord(0), random_coord(0), random_coord(0), 0, 0, 0));
         end else begin
            triangles_pending.push_back(make_triangle(random_id(), random_id(), random_id(),
               random_coord(wide), random_coord(wide), random_coord(wide),
               random_coord(wide), random_coord(wide), random_coord(wide),
               random_coord(wide), random_coord(wide), random_coord(wide)));
         end
      end
      total_triangles = triangles_pending.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (triangles_taken == total_triangles && coeffs_due.size() == 0);
      // Let a stray result show up if the block produces one.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (!failed && coeffs_due.size() == 0) begin
         $display("conformal_map_triangle_coefficients regression: pass");
      end else begin
         $display("conformal_map_triangle_coefficients regression: fail");
      end
      $finish;
   end

   // The timeout stops a run that hangs; a correct run ends well before it,
   // even with the heaviest stalls on both sides.
   initial begin
      #2000000;
      $display("conformal_map_triangle_coefficients regression: fail");
      $finish;
   end

endmodule
